// ===== design/swte_pkg.sv =====
// Shared constants and elaboration-time width helpers for the trend estimator.
`default_nettype none

package swte_pkg;

  // Fixed payload widths
  localparam int SAMPLE_W = 16;
  localparam int SLOPE_W  = 15;
  localparam int CHANGE_W = 17;

  // Largest sample value and the slope saturation limits
  localparam int SAMPLE_MAX = 65535;
  localparam int SLOPE_MAX  = 16383;
  localparam int SLOPE_MIN_MAG = 16384;

  // Width of the running sum of the window samples
  function automatic int sum_y_w(input int n);
    return $clog2(n * SAMPLE_MAX + 1);
  endfunction

  // Width of the running position-weighted sum
  function automatic int sum_iy_w(input int n);
    return $clog2((n * (n - 1) / 2) * SAMPLE_MAX + 1);
  endfunction

  // Signed width that holds n * sum(i*y) and the numerator
  function automatic int prod_w(input int n);
    return $clog2(n * (n * (n - 1) / 2) * SAMPLE_MAX + 1) + 1;
  endfunction

  // Sum of the absolute slope coefficients |n*i - n(n-1)/2|
  function automatic int sum_abs_coef(input int n);
    int acc;
    int c;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      c = n * i - n * (n - 1) / 2;
      acc = acc + ((c < 0) ? -c : c);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// ===== design/swte_if.sv =====
// Request channel interfaces: sample pairs in, trend results out.
`default_nettype none

interface swte_in_if import swte_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] mood_sample;
  logic [SAMPLE_W-1:0] fatigue_sample;

  modport source (output valid, output mood_sample, output fatigue_sample, input ready);
  modport sink   (input valid, input mood_sample, input fatigue_sample, output ready);
endinterface

interface swte_out_if import swte_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SLOPE_W-1:0]  mood_slope;
  logic signed [CHANGE_W-1:0] fatigue_change;
  logic                       trend_valid;

  modport source (output valid, output mood_slope, output fatigue_change,
                  output trend_valid, input ready);
  modport sink   (input valid, input mood_slope, input fatigue_change,
                  input trend_valid, output ready);
endinterface

`default_nettype wire

// ===== design/swte_window.sv =====
// Sample windows, running sums and fill count; first pipeline stage.
`default_nettype none

module swte_window import swte_pkg::*; #(
  parameter int WINDOW_LEN = 10,
  localparam int SUM_Y_W  = sum_y_w(WINDOW_LEN),
  localparam int SUM_IY_W = sum_iy_w(WINDOW_LEN),
  localparam int CNT_W    = $clog2(WINDOW_LEN + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output      logic                       in_ready_o,
  input  wire logic [SAMPLE_W-1:0]        mood_i,
  input  wire logic [SAMPLE_W-1:0]        fatigue_i,
  output      logic                       out_valid_o,
  input  wire logic                       out_ready_i,
  output      logic [SUM_Y_W-1:0]         sum_y_o,
  output      logic [SUM_IY_W-1:0]        sum_iy_o,
  output      logic signed [CHANGE_W-1:0] change_o,
  output      logic                       full_o
);

  logic [SAMPLE_W-1:0]        mood_q    [WINDOW_LEN];
  logic [SAMPLE_W-1:0]        fatigue_q [1:WINDOW_LEN-1];
  logic [SUM_Y_W-1:0]         sum_y_q, sum_y_d;
  logic [SUM_IY_W-1:0]        sum_iy_q, sum_iy_d;
  logic [SUM_Y_W-1:0]         sum_keep;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic signed [CHANGE_W-1:0] change_q, change_d;
  logic                       full_q;
  logic                       valid_q;
  logic                       accept;

  // Take a request when the stage is empty or its result is leaving
  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Slide the sums: drop the oldest sample, every position moves down by one
  always_comb begin
    sum_keep = sum_y_q - SUM_Y_W'(mood_q[0]);
    sum_y_d  = sum_keep + SUM_Y_W'(mood_i);
    sum_iy_d = sum_iy_q - SUM_IY_W'(sum_keep)
             + SUM_IY_W'(WINDOW_LEN - 1) * SUM_IY_W'(mood_i);
    cnt_d    = (cnt_q == CNT_W'(WINDOW_LEN)) ? cnt_q : cnt_q + CNT_W'(1);
    change_d = $signed(CHANGE_W'(fatigue_i)) - $signed(CHANGE_W'(fatigue_q[1]));
  end

  // Control and mood window: the window must read as zeros after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      cnt_q    <= '0;
      full_q   <= 1'b0;
      sum_y_q  <= '0;
      sum_iy_q <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        mood_q[i] <= '0;
      end
    end else begin
      if (accept) begin
        valid_q  <= 1'b1;
        cnt_q    <= cnt_d;
        full_q   <= (cnt_d == CNT_W'(WINDOW_LEN));
        sum_y_q  <= sum_y_d;
        sum_iy_q <= sum_iy_d;
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          mood_q[i] <= mood_q[i + 1];
        end
        mood_q[WINDOW_LEN - 1] <= mood_i;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Fatigue history and the change across the window
  always_ff @(posedge clk_i) begin
    if (accept) begin
      change_q <= change_d;
      for (int i = 1; i < WINDOW_LEN - 1; i++) begin
        fatigue_q[i] <= fatigue_q[i + 1];
      end
      fatigue_q[WINDOW_LEN - 1] <= fatigue_i;
    end
  end

  assign out_valid_o = valid_q;
  assign sum_y_o     = sum_y_q;
  assign sum_iy_o    = sum_iy_q;
  assign change_o    = change_q;
  assign full_o      = full_q;

endmodule

`default_nettype wire

// ===== design/swte_slope.sv =====
// Slope numerator, division by a constant via reciprocal multiply, clamp and output register.
`default_nettype none

module swte_slope import swte_pkg::*; #(
  parameter int WINDOW_LEN = 10,
  localparam int SUM_Y_W  = sum_y_w(WINDOW_LEN),
  localparam int SUM_IY_W = sum_iy_w(WINDOW_LEN)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output      logic                       in_ready_o,
  input  wire logic [SUM_Y_W-1:0]         sum_y_i,
  input  wire logic [SUM_IY_W-1:0]        sum_iy_i,
  input  wire logic signed [CHANGE_W-1:0] change_i,
  input  wire logic                       full_i,
  output      logic                       out_valid_o,
  input  wire logic                       out_ready_i,
  output      logic signed [SLOPE_W-1:0]  slope_o,
  output      logic signed [CHANGE_W-1:0] change_o,
  output      logic                       full_o
);

  localparam int S1      = WINDOW_LEN * (WINDOW_LEN - 1) / 2;
  localparam int DEN     = WINDOW_LEN * WINDOW_LEN * (WINDOW_LEN * WINDOW_LEN - 1) / 12;
  localparam int PROD_W  = prod_w(WINDOW_LEN);
  localparam int MAG_MAX = SAMPLE_MAX * sum_abs_coef(WINDOW_LEN) + DEN / 2;
  localparam int MW      = $clog2(MAG_MAX + 1);
  localparam int SHIFT   = MW + $clog2(DEN);
  localparam int RECIP_W = MW + 1;
  localparam int PW      = MW + RECIP_W;
  localparam int QW      = PW - SHIFT;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP64);

  logic [PROD_W-1:0]          num;
  logic [PROD_W-1:0]          num_abs;
  logic                       num_neg;

  // Numerator stage
  logic                       a_valid_q;
  logic [MW-1:0]              a_mag_q;
  logic                       a_neg_q;
  logic signed [CHANGE_W-1:0] a_change_q;
  logic                       a_full_q;
  // Multiply stage
  logic                       b_valid_q;
  logic [PW-1:0]              b_prod_q;
  logic                       b_neg_q;
  logic signed [CHANGE_W-1:0] b_change_q;
  logic                       b_full_q;
  // Output register
  logic                       c_valid_q;
  logic signed [SLOPE_W-1:0]  c_slope_q;
  logic signed [CHANGE_W-1:0] c_change_q;
  logic                       c_full_q;

  logic                       en_a, en_b, en_c;
  logic [QW-1:0]              quot;
  logic signed [SLOPE_W-1:0]  slope_d;

  // Advance each stage when it is empty or the next one takes its request
  assign en_c       = !c_valid_q || out_ready_i;
  assign en_b       = !b_valid_q || en_c;
  assign en_a       = !a_valid_q || en_b;
  assign in_ready_o = en_a;

  // Numerator N*sum(i*y) - S1*sum(y), split into sign and magnitude
  always_comb begin
    num     = PROD_W'(WINDOW_LEN) * PROD_W'(sum_iy_i) - PROD_W'(S1) * PROD_W'(sum_y_i);
    num_neg = num[PROD_W-1];
    num_abs = num_neg ? (PROD_W'(0) - num) : num;
  end

  // Rounded quotient and saturation; a partial window gives zero
  always_comb begin
    quot = b_prod_q[PW-1:SHIFT];
    if (!b_full_q) begin
      slope_d = '0;
    end else if (b_neg_q) begin
      if (32'(quot) > 32'(SLOPE_MIN_MAG)) begin
        slope_d = SLOPE_W'(0) - SLOPE_W'(SLOPE_MIN_MAG);
      end else begin
        slope_d = SLOPE_W'(0) - SLOPE_W'(quot);
      end
    end else begin
      if (32'(quot) > 32'(SLOPE_MAX)) begin
        slope_d = SLOPE_W'(SLOPE_MAX);
      end else begin
        slope_d = SLOPE_W'(quot);
      end
    end
  end

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (en_a) begin
        a_valid_q <= in_valid_i;
      end
      if (en_b) begin
        b_valid_q <= a_valid_q;
      end
      if (en_c) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (en_a) begin
      a_mag_q    <= MW'(num_abs) + MW'(DEN / 2);
      a_neg_q    <= num_neg;
      a_change_q <= change_i;
      a_full_q   <= full_i;
    end
    if (en_b) begin
      b_prod_q   <= PW'(a_mag_q) * PW'(RECIP);
      b_neg_q    <= a_neg_q;
      b_change_q <= a_change_q;
      b_full_q   <= a_full_q;
    end
    if (en_c) begin
      c_slope_q  <= slope_d;
      c_change_q <= b_full_q ? b_change_q : '0;
      c_full_q   <= b_full_q;
    end
  end

  assign out_valid_o = c_valid_q;
  assign slope_o     = c_slope_q;
  assign change_o    = c_change_q;
  assign full_o      = c_full_q;

endmodule

`default_nettype wire

// ===== design/sliding_window_trend_estimator.sv =====
// Top level of the sliding-window trend estimator.
`default_nettype none

// Takes one mood/fatigue sample pair per request and returns one result per
// request: the rounded least-squares slope of the newest WINDOW_LEN mood
// samples and the newest fatigue sample minus the oldest in its window.
// Until WINDOW_LEN pairs have arrived both trends read zero and trend_valid
// is low. One request is taken every clock cycle while the pipeline does not
// stall; a request passes the window update, the numerator and the reciprocal
// multiply, then the output register holds its result. The rate is set by the
// running sums, which are updated once per sample pair, and by the pipelined
// multiplier that stands in for the division by the constant denominator.
// Stalls on the result side fill pipeline bubbles before they hold the input
// side.
module sliding_window_trend_estimator import swte_pkg::*; #(
  parameter int WINDOW_LEN = 10
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  swte_in_if.sink        sample_i,
  swte_out_if.source     trend_o
);

  localparam int SUM_Y_W  = sum_y_w(WINDOW_LEN);
  localparam int SUM_IY_W = sum_iy_w(WINDOW_LEN);

  logic                       win_valid;
  logic                       win_ready;
  logic [SUM_Y_W-1:0]         win_sum_y;
  logic [SUM_IY_W-1:0]        win_sum_iy;
  logic signed [CHANGE_W-1:0] win_change;
  logic                       win_full;

  // Windows and running sums
  swte_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .mood_i      (sample_i.mood_sample),
    .fatigue_i   (sample_i.fatigue_sample),
    .out_valid_o (win_valid),
    .out_ready_i (win_ready),
    .sum_y_o     (win_sum_y),
    .sum_iy_o    (win_sum_iy),
    .change_o    (win_change),
    .full_o      (win_full)
  );

  // Slope division and result register
  swte_slope #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_slope (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (win_valid),
    .in_ready_o  (win_ready),
    .sum_y_i     (win_sum_y),
    .sum_iy_i    (win_sum_iy),
    .change_i    (win_change),
    .full_i      (win_full),
    .out_valid_o (trend_o.valid),
    .out_ready_i (trend_o.ready),
    .slope_o     (trend_o.mood_slope),
    .change_o    (trend_o.fatigue_change),
    .full_o      (trend_o.trend_valid)
  );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the sliding-window trend estimator.
`default_nettype none

module tb import swte_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_LEN     = 10;
  localparam int RAND_ITEMS  = 1000;
  localparam int CYCLE_LIMIT = 500000;

  // One trend result as the block should return it
  typedef struct packed {
    logic signed [SLOPE_W-1:0]  slope;
    logic signed [CHANGE_W-1:0] change;
    logic                       valid;
  } trend_t;

  // Tracks the sample windows and holds the trends still due from the block
  class trend_tracker;
    localparam int N = WIN_LEN;
    logic [SAMPLE_W-1:0] mood_hist[N];
    logic [SAMPLE_W-1:0] fatigue_hist[N];
    int                  held;
    trend_t              pending_trends[$];
    int                  failures;

    function new();
      for (int i = 0; i < N; i++) begin
        mood_hist[i]    = '0;
        fatigue_hist[i] = '0;
      end
      held     = 0;
      failures = 0;
    endfunction

    // Shift in a sample pair and queue the trend it produces
    function void note_sample(logic [SAMPLE_W-1:0] mood, logic [SAMPLE_W-1:0] fatigue);
      longint sum_y;
      longint sum_iy;
      longint num;
      longint mag;
      longint quo;
      longint den;
      trend_t exp_trend;
      sum_y  = 0;
      sum_iy = 0;
      den    = longint'(N) * N * (N * N - 1) / 12;
      for (int i = 0; i < N - 1; i++) begin
        mood_hist[i]    = mood_hist[i + 1];
        fatigue_hist[i] = fatigue_hist[i + 1];
      end
      mood_hist[N - 1]    = mood;
      fatigue_hist[N - 1] = fatigue;
      if (held < N) held++;
      exp_trend = '0;
      if (held >= N) begin
        for (int i = 0; i < N; i++) begin
          sum_y  += longint'(mood_hist[i]);
          sum_iy += longint'(i) * longint'(mood_hist[i]);
        end
        num = longint'(N) * sum_iy - longint'(N * (N - 1) / 2) * sum_y;
        // round half away from zero, then clamp to the slope range
        mag = (num < 0) ? -num : num;
        quo = (mag + den / 2) / den;
        if (num < 0) quo = -quo;
        if (quo > SLOPE_MAX) quo = SLOPE_MAX;
        if (quo < -longint'(SLOPE_MIN_MAG)) quo = -longint'(SLOPE_MIN_MAG);
        exp_trend.slope  = quo[SLOPE_W-1:0];
        exp_trend.change = CHANGE_W'(longint'(fatigue_hist[N - 1]) -
                                     longint'(fatigue_hist[0]));
        exp_trend.valid  = 1'b1;
      end
      pending_trends.insert(pending_trends.size(), exp_trend);
    endfunction

    // Compare one returned trend with the oldest one due
    function void check_trend(logic signed [SLOPE_W-1:0] slope,
                              logic signed [CHANGE_W-1:0] change, logic valid);
      trend_t exp_trend;
      if (pending_trends.size() == 0) begin
        $error("trend result returned with no request outstanding");
        failures++;
        return;
      end
      exp_trend = pending_trends[0];
      pending_trends.delete(0);
      if (slope !== exp_trend.slope) begin
        $error("mood_slope: expected %0d, got %0d", exp_trend.slope, slope);
        failures++;
      end
      if (change !== exp_trend.change) begin
        $error("fatigue_change: expected %0d, got %0d", exp_trend.change, change);
        failures++;
      end
      if (valid !== exp_trend.valid) begin
        $error("trend_valid: expected %0b, got %0b", exp_trend.valid, valid);
        failures++;
      end
    endfunction

    function int outstanding();
      return pending_trends.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  swte_in_if  sample_if ();
  swte_out_if trend_if ();

  sliding_window_trend_estimator #(.WINDOW_LEN(WIN_LEN)) dut (
    .clk_i    (clk),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .trend_o  (trend_if)
  );

  trend_tracker tracker;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int stall_left = 0;
  int cycles     = 0;

  initial begin
    tracker                  = new();
    sample_if.valid          = 1'b0;
    sample_if.mood_sample    = '0;
    sample_if.fatigue_sample = '0;
    trend_if.ready           = 1'b0;
  end

  always #1 clk = ~clk;

  // Abort a run that stops making progress
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Throttle the result side
  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        trend_if.ready <= 1'b0;
        stall_left--;
      end else begin
        trend_if.ready <= 1'b1;
        stall_left = pick_gap(rx_idle_on);
      end
    end
  end

  // Check every result taken
  always @(posedge clk) begin
    if (rst_ni && trend_if.valid && trend_if.ready)
      tracker.check_trend(trend_if.mood_slope, trend_if.fatigue_change,
                          trend_if.trend_valid);
  end

  // Offer one sample pair and hold it until the request is taken
  task automatic send_sample(input logic [SAMPLE_W-1:0] mood,
                             input logic [SAMPLE_W-1:0] fatigue, input int gap);
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_if.valid          <= 1'b1;
    sample_if.mood_sample    <= mood;
    sample_if.fatigue_sample <= fatigue;
    do @(posedge clk); while (!sample_if.ready);
    tracker.note_sample(mood, fatigue);
    @(negedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] clamp_sample(int v);
    if (v < 0) return '0;
    if (v > SAMPLE_MAX) return SAMPLE_W'(SAMPLE_MAX);
    return SAMPLE_W'(v);
  endfunction

  initial begin
    logic [SAMPLE_W-1:0] mood;
    logic [SAMPLE_W-1:0] fatigue;
    int                  mode;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // Directed: filling window, step up, full fatigue swings, ramp down,
    // alternating extremes
    for (int k = 0; k < 24; k++) begin
      if (k < 10) begin
        mood    = (k < 5) ? '0 : '1;
        fatigue = (k == 0) ? '0 : '1;
      end else if (k < 20) begin
        mood    = SAMPLE_W'((19 - k) * 7281);
        fatigue = (k == 10) ? '0 : 16'h8000;
      end else begin
        mood    = k[0] ? '1 : '0;
        fatigue = k[0] ? 16'h5555 : 16'haaaa;
      end
      send_sample(mood, fatigue, pick_gap(tx_idle_on));
    end

    // Random: full-range noise, smooth drifts and extremes
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k % 100 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
        mood    = SAMPLE_W'($urandom);
        fatigue = SAMPLE_W'($urandom);
      end else if (mode < 8) begin
        mood    = clamp_sample(int'(mood) + int'($urandom_range(0, 4000)) - 2000);
        fatigue = clamp_sample(int'(fatigue) + int'($urandom_range(0, 4000)) - 2000);
      end else if (mode == 8) begin
        mood    = $urandom_range(0, 1) ? '1 : '0;
        fatigue = $urandom_range(0, 1) ? '1 : '0;
      end else begin
        mood    = clamp_sample(int'(mood) + int'($urandom_range(0, 100)) - 50);
        fatigue = clamp_sample(int'(fatigue) + int'($urandom_range(0, 100)) - 50);
      end
      send_sample(mood, fatigue, pick_gap(tx_idle_on));
    end
    sample_if.valid <= 1'b0;

    // Drain the pipeline, then keep watching for stray results
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (tracker.failures == 0 && tracker.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== filelist.f =====
design/swte_pkg.sv
design/swte_if.sv
design/swte_window.sv
design/swte_slope.sv
design/sliding_window_trend_estimator.sv
verif/tb.sv
